>>> design/ftz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftz_pkg;

    // Input word: request kind and four raw sensor readings
    typedef struct packed {
        logic        req_type;
        logic [15:0] board_raw;
        logic [15:0] top_raw;
        logic [15:0] mid_raw;
        logic [15:0] lower_raw;
    } t_req;

    // Output word: fan command, zone, status and event pulses
    typedef struct packed {
        logic [7:0]        fan_value;
        logic              fan_write;
        logic              fan_via_table;
        logic [2:0]        zone;
        logic              status_error;
        logic signed [7:0] min_temp_out;
        logic signed [7:0] ctrl_temp_out;
        logic              irq_critical;
        logic              irq_hot;
        logic              irq_cold;
        logic              power_down_start;
        logic              heater_on;
    } t_res;

    // Fan drive levels and board options
    localparam logic [7:0] PWM_FULL        = 8'd255;
    localparam logic [7:0] PWM_LOW         = 8'd64;
    localparam logic [7:0] PWM_STOP        = 8'd0;
    localparam logic [7:0] PWM_SPAN        = PWM_FULL - PWM_LOW;
    localparam logic [7:0] SPIN_UP_TICKS   = 8'd4;
    localparam logic       HEATERS_PRESENT = 1'b1;
    localparam int         HYST_BAND       = 2;
    localparam logic signed [9:0] HYST_HALF = 10'(HYST_BAND / 2);

    // Ramp arithmetic widths: numerator and divisor fit 9 bits, product 17
    localparam int NUM_W     = 9;
    localparam int PROD_W    = 17;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Zone codes
    localparam logic [2:0] ZONE_CRIT     = 3'd0;
    localparam logic [2:0] ZONE_WARN     = 3'd1;
    localparam logic [2:0] ZONE_REGULATE = 3'd2;
    localparam logic [2:0] ZONE_COLD     = 3'd3;
    localparam logic [2:0] ZONE_IDLE     = 3'd4;
    localparam logic [2:0] ZONE_TICK     = 3'd5;

    // Request kinds
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_TARGET   = 3'd0;
    localparam logic [2:0] CFG_WARNING  = 3'd1;
    localparam logic [2:0] CFG_CRITICAL = 3'd2;
    localparam logic [2:0] CFG_FAN_OFF  = 3'd3;
    localparam logic [2:0] CFG_TOO_COLD = 3'd4;
    localparam logic [2:0] CFG_IRQ_EN   = 3'd5;
    localparam logic [2:0] CFG_OVERRIDE = 3'd6;

    // Configuration reset values
    localparam logic [7:0] RST_TARGET   = 8'd45;
    localparam logic [7:0] RST_WARNING  = 8'd70;
    localparam logic [7:0] RST_CRITICAL = 8'd85;
    localparam logic [7:0] RST_FAN_OFF  = 8'd30;
    localparam logic [7:0] RST_TOO_COLD = 8'd0;

endpackage

`default_nettype wire

>>> design/ftz_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ftz_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ftz_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [ftz_pkg::NUM_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [ftz_pkg::PROD_W-1:0]      o_quotient
);
    import ftz_pkg::*;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_W:0]       r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [NUM_W-1:0]     r_div;

    logic [NUM_W:0]       w_rem_sh;
    logic                 w_ge;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        w_rem_sh = {r_rem[NUM_W-1:0], r_quo[PROD_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
                r_quo <= {r_quo[PROD_W-2:0], w_ge};
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> design/fan_thermal_zone_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Fan and thermal zone controller. Each input word is either a set of four
// sensor readings or a spin-up tick; each produces exactly one output word
// with the fan command, thermal zone, status and event pulses. An accepted
// word waits in the done state until the output register is empty or its
// word is taken, and the input is free again as soon as it is loaded. A
// measurement that drives the linear fan ramp first forms the product, then
// runs through the bit-serial divider and then loads the output register.
// The input stalls while a word is in work, and also while a finished word
// cannot enter the output register because the word already there is
// stalled; once loaded, the output word waits there and the next input can
// already be taken. Write configuration only while the block is idle.
module fan_thermal_zone_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ftz_pkg::t_req i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ftz_pkg::t_res      o_out_word,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [7:0]    i_cfg_data
);
    import ftz_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Configuration registers
    logic signed [7:0] r_target, r_warning, r_critical, r_fan_off, r_too_cold;
    logic [2:0]        r_irq_en;
    logic              r_override;

    // Controller state
    t_state            r_state;
    logic              r_reg_act;
    logic              r_crit_lat;
    logic              r_spin_act;
    logic [7:0]        r_spin_cnt;

    // Word in work and output register
    t_res              r_pend;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_den;
    t_res              r_out;
    logic              r_out_valid;

    // Decode results of the word on the input
    t_res              w_res;
    logic              w_need_div;
    logic              w_reg_next;
    logic              w_crit_next;
    logic              w_spin_next;
    logic [7:0]        w_cnt_next;
    logic signed [7:0] w_s0, w_s1, w_s2, w_s3, w_mn;
    logic signed [9:0] w_t, w_tgt, w_warn, w_hi, w_lo, w_num, w_den;
    logic              w_may_drive;
    logic              w_accept;

    // Divider hookup
    logic              w_div_start;
    logic              w_div_done;
    logic [PROD_W-1:0] w_quo;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_sum;
    logic [7:0]        w_ramp;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Classify the word and form its result
    always_comb begin
        w_s0 = signed'(i_in_word.board_raw[15:8]);
        w_s1 = signed'(i_in_word.top_raw[15:8]);
        w_s2 = signed'(i_in_word.mid_raw[15:8]);
        w_s3 = signed'(i_in_word.lower_raw[15:8]);
        w_mn = w_s0;
        if (w_s1 < w_mn) w_mn = w_s1;
        if (w_s2 < w_mn) w_mn = w_s2;
        if (w_s3 < w_mn) w_mn = w_s3;

        w_t    = 10'(w_s2);
        w_tgt  = 10'(r_target);
        w_warn = 10'(r_warning);
        w_hi   = w_tgt + HYST_HALF;
        w_lo   = w_tgt - HYST_HALF;
        w_num  = w_t - w_lo;
        w_den  = w_warn - w_lo;
        w_may_drive = !r_spin_act && !r_override;

        w_res       = '0;
        w_need_div  = 1'b0;
        w_reg_next  = r_reg_act;
        w_crit_next = r_crit_lat;
        w_spin_next = r_spin_act;
        w_cnt_next  = r_spin_cnt;

        if (i_in_word.req_type == REQ_TICK) begin
            w_res.zone = ZONE_TICK;
            if (r_spin_act) begin
                if (r_spin_cnt != 8'hFF) w_cnt_next = r_spin_cnt + 1'b1;
                if (r_spin_cnt >= SPIN_UP_TICKS - 8'd1) begin
                    w_res.fan_value = PWM_LOW;
                    w_res.fan_write = 1'b1;
                    w_spin_next     = 1'b0;
                end
            end
        end else begin
            w_res.min_temp_out  = w_mn;
            w_res.ctrl_temp_out = w_s2;
            w_reg_next = (w_t >= w_hi) || (r_reg_act && (w_t >= w_lo));

            if (w_s2 >= r_critical) begin
                w_res.zone         = ZONE_CRIT;
                w_res.irq_critical = r_irq_en[0];
                if (w_may_drive) begin
                    w_res.fan_value = PWM_FULL;
                    w_res.fan_write = 1'b1;
                end
                if (!r_crit_lat) begin
                    w_res.power_down_start = 1'b1;
                    w_crit_next            = 1'b1;
                end
            end else if (w_s2 >= r_warning) begin
                w_res.zone         = ZONE_WARN;
                w_res.status_error = 1'b1;
                w_res.irq_hot      = r_irq_en[1];
                if (w_may_drive) begin
                    w_res.fan_value = PWM_FULL;
                    w_res.fan_write = 1'b1;
                end
            end else if (w_s2 > r_fan_off) begin
                w_res.zone = ZONE_REGULATE;
                if (w_may_drive) begin
                    w_res.fan_write = 1'b1;
                    if (w_reg_next) begin
                        w_res.fan_via_table = 1'b1;
                        if (w_den <= 10'sd0) begin
                            w_res.fan_value = PWM_FULL;
                        end else if (w_num < 10'sd0) begin
                            w_res.fan_value = PWM_LOW;
                        end else begin
                            w_need_div = 1'b1;
                        end
                    end else begin
                        w_res.fan_value = PWM_LOW;
                    end
                end
            end else if (w_s2 <= r_too_cold) begin
                w_res.zone         = ZONE_COLD;
                w_res.status_error = 1'b1;
                w_res.fan_value    = PWM_STOP;
                w_res.fan_write    = 1'b1;
                w_res.irq_cold     = r_irq_en[2];
                w_res.heater_on    = HEATERS_PRESENT;
            end else begin
                w_res.zone = ZONE_IDLE;
                if (w_may_drive) begin
                    w_res.fan_value = PWM_STOP;
                    w_res.fan_write = 1'b1;
                end
            end
        end
    end

    // Ramp product feeds the divider register directly
    assign w_div_start = (r_state == ST_MUL);
    assign w_prod      = {{(PROD_W-NUM_W){1'b0}}, r_num} * {{(PROD_W-8){1'b0}}, PWM_SPAN};

    ftz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Offset and clamp the quotient
    always_comb begin
        w_sum = {1'b0, w_quo} + (PROD_W+1)'(PWM_LOW);
        if (w_sum > (PROD_W+1)'(PWM_FULL)) begin
            w_ramp = PWM_FULL;
        end else if (w_sum < (PROD_W+1)'(PWM_LOW)) begin
            w_ramp = PWM_LOW;
        end else begin
            w_ramp = w_sum[7:0];
        end
    end

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= signed'(RST_TARGET);
            r_warning   <= signed'(RST_WARNING);
            r_critical  <= signed'(RST_CRITICAL);
            r_fan_off   <= signed'(RST_FAN_OFF);
            r_too_cold  <= signed'(RST_TOO_COLD);
            r_irq_en    <= '0;
            r_override  <= 1'b0;
            r_reg_act   <= 1'b0;
            r_crit_lat  <= 1'b0;
            r_spin_act  <= 1'b1;
            r_spin_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET:   r_target   <= signed'(i_cfg_data);
                    CFG_WARNING:  r_warning  <= signed'(i_cfg_data);
                    CFG_CRITICAL: r_critical <= signed'(i_cfg_data);
                    CFG_FAN_OFF:  r_fan_off  <= signed'(i_cfg_data);
                    CFG_TOO_COLD: r_too_cold <= signed'(i_cfg_data);
                    CFG_IRQ_EN:   r_irq_en   <= i_cfg_data[2:0];
                    CFG_OVERRIDE: r_override <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // Drop the output word once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pend     <= w_res;
                        r_num      <= w_num[NUM_W-1:0];
                        r_den      <= w_den[NUM_W-1:0];
                        r_reg_act  <= w_reg_next;
                        r_crit_lat <= w_crit_next;
                        r_spin_act <= w_spin_next;
                        r_spin_cnt <= w_cnt_next;
                        r_state    <= w_need_div ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_pend.fan_value <= w_ramp;
                        r_state          <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Power-down latch never clears outside reset
    a_crit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crit_lat |=> r_crit_lat)
        else $error("critical latch cleared");

    // Power-down pulse only from critical zone, and only while latch was clear
    a_pd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && r_pend.power_down_start |->
            (r_pend.zone == ZONE_CRIT) && r_crit_lat)
        else $error("power down pulse outside first critical entry");

    // Table-driven commands stay within the ramp range
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.fan_via_table |->
            (o_out_word.fan_value >= PWM_LOW) && o_out_word.fan_write &&
            (o_out_word.zone == ZONE_REGULATE))
        else $error("ramp value out of range");

    // No command means a zero fan value
    a_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.fan_write |->
            (o_out_word.fan_value == PWM_STOP) && !o_out_word.fan_via_table)
        else $error("fan value without command");

    // Divider only finishes while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider result outside divide state");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ftz_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_IDLE      = 14;
    localparam int RAND_PHASES   = 19;
    localparam int PHASE_WORDS   = 50;
    localparam int PRINT_CAP     = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_req       in_word = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_idx = CFG_TARGET;
    logic [7:0] cfg_data = 8'd0;
    logic       in_stall;
    logic       out_valid;
    t_res       out_word;

    // Shadow copy of the thermal settings and controller state
    logic signed [7:0] target_c, warning_c, critical_c, fan_off_c, too_cold_c;
    logic [2:0]        irq_mask_c;
    logic              override_c;
    logic              regulating, crit_latched, spinning;
    logic [7:0]        spin_ticks;

    t_res expected_q[$];
    int   err_count = 0;
    int   checked = 0;
    int   words_sent = 0;
    int   config_count = 0;
    int   ramp_hits = 0;
    int   zone_hits[6];
    int   cycles = 0;
    int   stall_left = 0;
    int   walk_t = 45;
    logic no_idle = 1'b0;

    fan_thermal_zone_controller u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: end the run if the block hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Expected fan command and zone report for one word; advances the shadow state
    function automatic t_res thermal_response(input t_req w);
        t_res r;
        int   s_board, s_top, s_lower, t, mn, lo, hi, den, num, v;
        logic may_drive, last_tick;
        r = '0;
        if (w.req_type == REQ_TICK) begin
            r.zone = ZONE_TICK;
            if (spinning) begin
                last_tick = (spin_ticks >= SPIN_UP_TICKS - 8'd1);
                if (spin_ticks != 8'hFF) spin_ticks = spin_ticks + 8'd1;
                if (last_tick) begin
                    r.fan_value = PWM_LOW;
                    r.fan_write = 1'b1;
                    spinning    = 1'b0;
                end
            end
            return r;
        end
        s_board = $signed(w.board_raw[15:8]);
        s_top   = $signed(w.top_raw[15:8]);
        t       = $signed(w.mid_raw[15:8]);
        s_lower = $signed(w.lower_raw[15:8]);
        hi = target_c + HYST_BAND / 2;
        lo = target_c - HYST_BAND / 2;
        may_drive = !spinning && !override_c;
        mn = s_board;
        if (s_top < mn) mn = s_top;
        if (t < mn) mn = t;
        if (s_lower < mn) mn = s_lower;
        r.min_temp_out  = mn[7:0];
        r.ctrl_temp_out = t[7:0];
        regulating = (t >= hi) || (regulating && t >= lo);

        if (t >= critical_c) begin
            r.zone         = ZONE_CRIT;
            r.irq_critical = irq_mask_c[0];
            if (may_drive) begin
                r.fan_value = PWM_FULL;
                r.fan_write = 1'b1;
            end
            // power-down fires on the first critical entry only
            if (!crit_latched) begin
                r.power_down_start = 1'b1;
                crit_latched       = 1'b1;
            end
        end else if (t >= warning_c) begin
            r.zone         = ZONE_WARN;
            r.status_error = 1'b1;
            r.irq_hot      = irq_mask_c[1];
            if (may_drive) begin
                r.fan_value = PWM_FULL;
                r.fan_write = 1'b1;
            end
        end else if (t > fan_off_c) begin
            r.zone = ZONE_REGULATE;
            if (may_drive) begin
                r.fan_write = 1'b1;
                if (regulating) begin
                    // linear ramp from target-1 to warning, computed wide then clamped
                    den = warning_c - lo;
                    num = t - lo;
                    if (den <= 0) v = PWM_FULL;
                    else if (num < 0) v = PWM_LOW;
                    else v = num * (PWM_FULL - PWM_LOW) / den + PWM_LOW;
                    if (v > PWM_FULL) v = PWM_FULL;
                    if (v < PWM_LOW) v = PWM_LOW;
                    r.fan_value     = v[7:0];
                    r.fan_via_table = 1'b1;
                end else begin
                    r.fan_value = PWM_LOW;
                end
            end
        end else if (t <= too_cold_c) begin
            // cold zone stops the fan even during spin-up or host override
            r.zone         = ZONE_COLD;
            r.status_error = 1'b1;
            r.fan_value    = PWM_STOP;
            r.fan_write    = 1'b1;
            r.irq_cold     = irq_mask_c[2];
            r.heater_on    = HEATERS_PRESENT;
        end else begin
            r.zone = ZONE_IDLE;
            if (may_drive) begin
                r.fan_value = PWM_STOP;
                r.fan_write = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int clamp_temp(input int v);
        if (v > 127) return 127;
        if (v < -128) return -128;
        return v;
    endfunction

    // One measurement word with the given Celsius upper bytes and random low bytes
    function automatic t_req sensor_set(input int m, input int b, input int tp, input int lw);
        t_req w;
        w.req_type  = REQ_MEASURE;
        w.board_raw = {b[7:0], 8'($urandom)};
        w.top_raw   = {tp[7:0], 8'($urandom)};
        w.mid_raw   = {m[7:0], 8'($urandom)};
        w.lower_raw = {lw[7:0], 8'($urandom)};
        return w;
    endfunction

    function automatic t_req tick_word();
        t_req w;
        w.board_raw = 16'($urandom);
        w.top_raw   = 16'($urandom);
        w.mid_raw   = 16'($urandom);
        w.lower_raw = 16'($urandom);
        w.req_type  = REQ_TICK;
        return w;
    endfunction

    // Temperature near one of the current thresholds, a hysteresis walk, or anything
    function automatic int pick_temp();
        int base;
        case ($urandom_range(0, 8))
            0, 1: return int'($urandom_range(0, 255)) - 128;
            2: base = target_c;
            3: base = warning_c;
            4: base = critical_c;
            5: base = fan_off_c;
            6: base = too_cold_c;
            default: begin
                walk_t = clamp_temp(walk_t + int'($urandom_range(0, 8)) - 4);
                return walk_t;
            end
        endcase
        return clamp_temp(base + int'($urandom_range(0, 6)) - 3);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        // keep the log short on a badly broken build
        if (err_count <= PRINT_CAP)
            $display("MISMATCH word %0d %s: got %0d expected %0d", checked, what, got, want);
    endtask

    task automatic check_word(input t_res got, input t_res want);
        if (got.fan_value !== want.fan_value)
            report_mismatch("fan_value", got.fan_value, want.fan_value);
        if (got.fan_write !== want.fan_write)
            report_mismatch("fan_write", got.fan_write, want.fan_write);
        if (got.fan_via_table !== want.fan_via_table)
            report_mismatch("fan_via_table", got.fan_via_table, want.fan_via_table);
        if (got.zone !== want.zone)
            report_mismatch("zone", got.zone, want.zone);
        if (got.status_error !== want.status_error)
            report_mismatch("status_error", got.status_error, want.status_error);
        if (got.min_temp_out !== want.min_temp_out)
            report_mismatch("min_temp_out", got.min_temp_out, want.min_temp_out);
        if (got.ctrl_temp_out !== want.ctrl_temp_out)
            report_mismatch("ctrl_temp_out", got.ctrl_temp_out, want.ctrl_temp_out);
        if (got.irq_critical !== want.irq_critical)
            report_mismatch("irq_critical", got.irq_critical, want.irq_critical);
        if (got.irq_hot !== want.irq_hot)
            report_mismatch("irq_hot", got.irq_hot, want.irq_hot);
        if (got.irq_cold !== want.irq_cold)
            report_mismatch("irq_cold", got.irq_cold, want.irq_cold);
        if (got.power_down_start !== want.power_down_start)
            report_mismatch("power_down_start", got.power_down_start, want.power_down_start);
        if (got.heater_on !== want.heater_on)
            report_mismatch("heater_on", got.heater_on, want.heater_on);
    endtask

    // Accept result words with random stalls and compare against the oldest expectation
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("word with nothing expected, zone", out_word.zone, -1);
                end else begin
                    zone_hits[expected_q[0].zone]++;
                    if (expected_q[0].fan_via_table) ramp_hits++;
                    check_word(out_word, expected_q.pop_front());
                end
                checked++;
                stall_left = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input t_req w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.push_back(thermal_response(w));
        words_sent++;
    endtask

    task automatic measure(input int m, input int b, input int tp, input int lw);
        send_word(sensor_set(m, b, tp, lw));
    endtask

    // Drop valid and hold off until every result is back and the block is quiet
    task automatic wait_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input int tgt, input int warn, input int crit, input int off,
                              input int cold, input logic [2:0] mask, input logic ovr);
        wait_results();
        put_reg(CFG_TARGET, 8'(tgt));
        put_reg(CFG_WARNING, 8'(warn));
        put_reg(CFG_CRITICAL, 8'(crit));
        put_reg(CFG_FAN_OFF, 8'(off));
        put_reg(CFG_TOO_COLD, 8'(cold));
        put_reg(CFG_IRQ_EN, {5'd0, mask});
        put_reg(CFG_OVERRIDE, {7'd0, ovr});
        cfg_we     <= 1'b0;
        target_c   = 8'(tgt);
        warning_c  = 8'(warn);
        critical_c = 8'(crit);
        fan_off_c  = 8'(off);
        too_cold_c = 8'(cold);
        irq_mask_c = mask;
        override_c = ovr;
        walk_t     = tgt;
        config_count++;
    endtask

    // Reset settings: zones while spinning up, the spin-up ticks, then every zone
    // and the hysteresis band with the fan under block control
    task automatic test_boot_sequence();
        measure(0, 0, 0, 0);
        measure(-1, -1, -1, -1);
        measure(127, -128, 100, 5);
        measure(75, 80, 75, 90);
        repeat (5) send_word(tick_word());
        measure(90, 95, 91, 99);
        measure(75, 76, 20, 80);
        measure(40, 41, 42, 12);
        measure(46, 47, 48, 49);
        measure(44, 44, 50, 50);
        measure(43, 43, 43, 43);
        measure(45, -7, 60, 60);
        measure(20, 30, 40, 50);
        measure(31, 32, 33, 34);
        measure(69, 70, 71, 72);
        measure(-128, 127, 127, 127);
    endtask

    // Widest ramp: target at the bottom, warning at the top
    task automatic test_ramp_extremes();
        set_config(-128, 127, 127, -128, -128, 3'd7, 1'b0);
        measure(126, 126, 126, 126);
        measure(-127, -100, 0, 100);
        measure(127, 0, 0, 0);
    endtask

    // Host owns the fan: only the cold zone still commands it
    task automatic test_host_override();
        set_config(45, 70, 85, 30, 0, 3'd7, 1'b1);
        measure(75, 70, 75, 80);
        measure(-10, -10, -9, -8);
        measure(50, 51, 52, 53);
    endtask

    // Random settings per phase, mostly ordered thresholds, with hot-spot stimulus
    task automatic test_random_settings();
        int ph, n, tgt, warn, crit, off, cold;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            case (ph)
                0: set_config(127, 127, 127, 127, 127, 3'd0, 1'b0);
                1: set_config(-128, -128, -128, -128, -128, 3'd7, 1'b1);
                2: set_config(-128, 127, 127, -128, -128, 3'd5, 1'b0);
                default: begin
                    if ($urandom_range(0, 3) != 0) begin
                        cold = int'($urandom_range(0, 188)) - 128;
                        off  = clamp_temp(cold + int'($urandom_range(0, 30)));
                        tgt  = clamp_temp(off + int'($urandom_range(0, 30)));
                        warn = clamp_temp(tgt + int'($urandom_range(1, 30)));
                        crit = clamp_temp(warn + int'($urandom_range(0, 20)));
                    end else begin
                        cold = int'($urandom_range(0, 255)) - 128;
                        off  = int'($urandom_range(0, 255)) - 128;
                        tgt  = int'($urandom_range(0, 255)) - 128;
                        warn = int'($urandom_range(0, 255)) - 128;
                        crit = int'($urandom_range(0, 255)) - 128;
                    end
                    set_config(tgt, warn, crit, off, cold, 3'($urandom_range(0, 7)),
                               $urandom_range(0, 4) == 0);
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++) begin
                // hold off mid-phase until the pipeline is empty
                if (ph == 5 && n == PHASE_WORDS / 2) wait_results();
                if ($urandom_range(0, 11) == 0)
                    send_word(tick_word());
                else if ($urandom_range(0, 3) == 0)
                    send_word(sensor_set(pick_temp(), int'($urandom), int'($urandom),
                                         int'($urandom)));
                else
                    measure(pick_temp(), pick_temp(), pick_temp(), pick_temp());
            end
        end
    endtask

    initial begin
        target_c     = $signed(RST_TARGET);
        warning_c    = $signed(RST_WARNING);
        critical_c   = $signed(RST_CRITICAL);
        fan_off_c    = $signed(RST_FAN_OFF);
        too_cold_c   = $signed(RST_TOO_COLD);
        irq_mask_c   = 3'd0;
        override_c   = 1'b0;
        regulating   = 1'b0;
        crit_latched = 1'b0;
        spinning     = 1'b1;
        spin_ticks   = 8'd0;
        foreach (zone_hits[z]) zone_hits[z] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boot_sequence();
        test_ramp_extremes();
        test_host_override();
        test_random_settings();
        wait_results();

        $display("Summary: %0d words sent, %0d results checked, %0d register settings",
                 words_sent, checked, config_count);
        $display("Zones crit %0d warn %0d regulate %0d cold %0d idle %0d tick %0d, ramp %0d",
                 zone_hits[0], zone_hits[1], zone_hits[2], zone_hits[3], zone_hits[4],
                 zone_hits[5], ramp_hits);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
